@@ hw/rtl/record_ring_buffer_assert.svh @@
// Assertion macros for the record ring buffer checker.
`ifndef RECORD_RING_BUFFER_ASSERT_SVH
`define RECORD_RING_BUFFER_ASSERT_SVH

// Checked outside reset.
`define RRB_ASSERT(lbl, prop, msg) lbl: assert property (@(posedge clock) \
   disable iff (reset) prop) else $error(msg);

// Checked on every edge, reset included.
`define RRB_ASSERT_ALWAYS(lbl, prop, msg) lbl: assert property (@(posedge clock) \
   prop) else $error(msg);

`endif

@@ hw/rtl/rrb_pkg.sv @@
// Package: item types, codes and helpers for the record ring buffer.
package rrb_pkg;

   localparam int RRB_RING_BYTES   = 65536;
   localparam int RRB_HEADER_BYTES = 16;

   localparam logic [1:0] MODE_START = 2'd0;
   localparam logic [1:0] MODE_WRITE = 2'd1;
   localparam logic [1:0] MODE_READ  = 2'd2;

   localparam logic [2:0] ST_OK         = 3'd0;
   localparam logic [2:0] ST_NO_ROOM    = 3'd1;
   localparam logic [2:0] ST_BAD_LENGTH = 3'd2;
   localparam logic [2:0] ST_NO_RECORD  = 3'd3;
   localparam logic [2:0] ST_OPEN       = 3'd4;
   localparam logic [2:0] ST_EMPTY      = 3'd5;

   typedef struct packed {
      logic [1:0]  mode;
      logic [15:0] record_length;
      logic [47:0] file_offset;
      logic [7:0]  data_byte;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic        out_valid;
      logic [7:0]  out_byte;
      logic [47:0] out_offset;
      logic        first_of_record;
      logic        last_of_record;
      logic [15:0] free_bytes;
   } rsp_type;

   // header word is {offset, length}; bytes 8 and up read as zero
   function automatic logic [7:0] rrb_hdr_byte(input logic [63:0] word,
                                               input logic [4:0]  idx);
      logic [7:0] b;
      b = 8'd0;
      if (idx < 5'd8) begin
         b = word[{idx[2:0], 3'b000} +: 8];
      end
      return b;
   endfunction

endpackage

@@ hw/rtl/rrb_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module rrb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

@@ hw/rtl/record_ring_buffer.sv @@
// Top level: byte ring buffer of whole records, one RAM holds headers and data.
//
//  channel  ports                  handshake
//  request  req_item              start && !busy
//  result   rsp_item              rsp_strobe, one cycle, no backpressure
//
// Data write: handled in S_IDLE, busy stays low. Read of a byte inside a record:
// S_DATA_RD. Read that opens a record: S_HDR_RD, S_HDR_CHK, S_DATA_RD (header
// fetch of min(8,HEADER_BYTES) bytes via the single RAM read port). Record start:
// S_HDR_WR when admitted (header bytes go through the single RAM write port), else
// answered from S_IDLE. Reset is synchronous; the ring contents need no clearing.
// Results are registered and come in the cycle after the item completes; the receiver cannot stall.
module record_ring_buffer #(
   parameter int RING_BYTES   = rrb_pkg::RRB_RING_BYTES,
   parameter int HEADER_BYTES = rrb_pkg::RRB_HEADER_BYTES
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  rrb_pkg::req_type req_item,
   output logic             rsp_strobe,
   output rrb_pkg::rsp_type rsp_item
);
   import rrb_pkg::*;

   localparam int AW = $clog2(RING_BYTES);
   localparam int CW = $clog2(HEADER_BYTES + 1);
   localparam int HN = (HEADER_BYTES < 8) ? HEADER_BYTES : 8;

   localparam logic [2:0] S_IDLE    = 3'd0;
   localparam logic [2:0] S_HDR_WR  = 3'd1;
   localparam logic [2:0] S_HDR_RD  = 3'd2;
   localparam logic [2:0] S_HDR_CHK = 3'd3;
   localparam logic [2:0] S_DATA_RD = 3'd4;

   function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] p,
                                              input logic [AW-1:0] n);
      logic [AW:0] s;
      s = {1'b0, p} + {1'b0, n};
      if (s >= (AW+1)'(RING_BYTES)) begin
         s = s - (AW+1)'(RING_BYTES);
      end
      return s[AW-1:0];
   endfunction

   function automatic logic [AW-1:0] used_of(input logic [AW-1:0] ce,
                                             input logic [AW-1:0] rs);
      logic [AW:0] t;
      t = (AW+1)'(ce) + (AW+1)'(RING_BYTES) - (AW+1)'(rs);
      if (ce >= rs) begin
         t = (AW+1)'(ce - rs);
      end
      return t[AW-1:0];
   endfunction

   function automatic logic [15:0] free16(input logic [AW-1:0] used);
      logic [AW-1:0]  f;
      logic [AW+15:0] e;
      f = AW'(RING_BYTES - 1) - used;
      e = (AW+16)'(f);
      return e[15:0];
   endfunction

   logic [2:0]    state_ff, state_in;
   logic [AW-1:0] rs_ff, rs_in;
   logic [AW-1:0] ce_ff, ce_in;
   logic [AW-1:0] wpos_ff, wpos_in;
   logic [15:0]   wrem_ff, wrem_in;
   logic          wopen_ff, wopen_in;
   logic [AW-1:0] rpos_ff, rpos_in;
   logic [15:0]   rrem_ff, rrem_in;
   logic          ractive_ff, ractive_in;
   logic [47:0]   rboff_ff, rboff_in;
   logic          strobe_ff, strobe_in;
   rsp_type       rsp_ff, rsp_in;
   logic [63:0]   hdr_ff, hdr_in;
   logic [AW-1:0] wa_ff, wa_in;
   logic [AW-1:0] ra_ff, ra_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          first_ff, first_in;

   logic          wr_en, rd_en;
   logic [AW-1:0] wr_addr, rd_addr;
   logic [7:0]    wr_data, rd_q;

   logic [AW-1:0] used_now;
   logic [31:0]   need;
   logic [4:0]    cap_idx;
   logic          hdr_bad;

   rrb_ram #(
      .WIDTH (8),
      .DEPTH (RING_BYTES)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_q)
   );

   assign busy       = (state_ff != S_IDLE);
   assign rsp_strobe = strobe_ff;
   assign rsp_item   = rsp_ff;

   assign used_now = used_of(ce_ff, rs_ff);
   assign need     = 32'(HEADER_BYTES) + 32'(req_item.record_length);
   assign cap_idx  = 5'(cnt_ff) - 5'd1;
   assign hdr_bad  = (hdr_ff[15:0] == 16'd0) ||
                     (32'(hdr_ff[15:0]) + 32'(HEADER_BYTES) > 32'(used_now));

   always_comb begin
      state_in   = state_ff;
      rs_in      = rs_ff;
      ce_in      = ce_ff;
      wpos_in    = wpos_ff;
      wrem_in    = wrem_ff;
      wopen_in   = wopen_ff;
      rpos_in    = rpos_ff;
      rrem_in    = rrem_ff;
      ractive_in = ractive_ff;
      rboff_in   = rboff_ff;
      hdr_in     = hdr_ff;
      wa_in      = wa_ff;
      ra_in      = ra_ff;
      cnt_in     = cnt_ff;
      first_in   = first_ff;
      strobe_in  = 1'b0;
      rsp_in     = '0;
      wr_en      = 1'b0;
      wr_addr    = wpos_ff;
      wr_data    = req_item.data_byte;
      rd_en      = 1'b0;
      rd_addr    = rpos_ff;

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               case (req_item.mode)
                  MODE_START: begin
                     if (wopen_ff) begin
                        strobe_in     = 1'b1;
                        rsp_in.status = ST_OPEN;
                     end else if (req_item.record_length == 16'd0 ||
                                  need > 32'(RING_BYTES - 1)) begin
                        strobe_in     = 1'b1;
                        rsp_in.status = ST_BAD_LENGTH;
                     end else if (need > 32'(free16(used_now)) + 32'(0) &&
                                  need > 32'(AW'(RING_BYTES - 1) - used_now)) begin
                        strobe_in     = 1'b1;
                        rsp_in.status = ST_NO_ROOM;
                     end else begin
                        hdr_in   = {req_item.file_offset, req_item.record_length};
                        wa_in    = ce_ff;
                        cnt_in   = '0;
                        state_in = S_HDR_WR;
                     end
                  end
                  MODE_WRITE: begin
                     strobe_in = 1'b1;
                     if (!wopen_ff) begin
                        rsp_in.status = ST_NO_RECORD;
                     end else begin
                        wr_en   = 1'b1;
                        wpos_in = wrap_add(wpos_ff, AW'(1));
                        wrem_in = wrem_ff - 16'd1;
                        if (wrem_ff == 16'd1) begin
                           ce_in    = wpos_in;
                           wopen_in = 1'b0;
                        end
                     end
                  end
                  MODE_READ: begin
                     if (ractive_ff) begin
                        rd_en    = 1'b1;
                        rd_addr  = rpos_ff;
                        first_in = 1'b0;
                        state_in = S_DATA_RD;
                     end else if (used_now == '0) begin
                        strobe_in     = 1'b1;
                        rsp_in.status = ST_EMPTY;
                     end else begin
                        rd_en    = 1'b1;
                        rd_addr  = rs_ff;
                        ra_in    = wrap_add(rs_ff, AW'(1));
                        cnt_in   = CW'(1);
                        hdr_in   = '0;
                        state_in = S_HDR_RD;
                     end
                  end
                  default: begin
                     strobe_in = 1'b1;
                  end
               endcase
            end
         end
         S_HDR_WR: begin
            wr_en   = 1'b1;
            wr_addr = wa_ff;
            wr_data = rrb_hdr_byte(hdr_ff, 5'(cnt_ff));
            wa_in   = wrap_add(wa_ff, AW'(1));
            cnt_in  = cnt_ff + CW'(1);
            if (cnt_ff == CW'(HEADER_BYTES - 1)) begin
               wpos_in   = wa_in;
               wrem_in   = hdr_ff[15:0];
               wopen_in  = 1'b1;
               strobe_in = 1'b1;
               state_in  = S_IDLE;
            end
         end
         S_HDR_RD: begin
            hdr_in[{cap_idx[2:0], 3'b000} +: 8] = rd_q;
            if (cnt_ff < CW'(HN)) begin
               rd_en   = 1'b1;
               rd_addr = ra_ff;
               ra_in   = wrap_add(ra_ff, AW'(1));
               cnt_in  = cnt_ff + CW'(1);
            end else begin
               state_in = S_HDR_CHK;
            end
         end
         S_HDR_CHK: begin
            if (hdr_bad) begin
               rs_in         = ce_ff;
               strobe_in     = 1'b1;
               rsp_in.status = ST_EMPTY;
               state_in      = S_IDLE;
            end else begin
               rpos_in    = wrap_add(rs_ff, AW'(HEADER_BYTES));
               rd_en      = 1'b1;
               rd_addr    = rpos_in;
               rrem_in    = hdr_ff[15:0];
               rboff_in   = hdr_ff[63:16];
               ractive_in = 1'b1;
               first_in   = 1'b1;
               state_in   = S_DATA_RD;
            end
         end
         S_DATA_RD: begin
            strobe_in              = 1'b1;
            rsp_in.out_valid       = 1'b1;
            rsp_in.out_byte        = rd_q;
            rsp_in.out_offset      = rboff_ff;
            rsp_in.first_of_record = first_ff;
            rboff_in               = rboff_ff + 48'd1;
            rpos_in                = wrap_add(rpos_ff, AW'(1));
            rrem_in                = rrem_ff - 16'd1;
            if (rrem_ff == 16'd1) begin
               rsp_in.last_of_record = 1'b1;
               rs_in                 = rpos_in;
               ractive_in            = 1'b0;
            end
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      rsp_in.free_bytes = free16(used_of(ce_in, rs_in));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         rs_ff      <= '0;
         ce_ff      <= '0;
         wpos_ff    <= '0;
         wrem_ff    <= '0;
         wopen_ff   <= 1'b0;
         rpos_ff    <= '0;
         rrem_ff    <= '0;
         ractive_ff <= 1'b0;
         rboff_ff   <= '0;
         strobe_ff  <= 1'b0;
      end else begin
         state_ff   <= state_in;
         rs_ff      <= rs_in;
         ce_ff      <= ce_in;
         wpos_ff    <= wpos_in;
         wrem_ff    <= wrem_in;
         wopen_ff   <= wopen_in;
         rpos_ff    <= rpos_in;
         rrem_ff    <= rrem_in;
         ractive_ff <= ractive_in;
         rboff_ff   <= rboff_in;
         strobe_ff  <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff   <= rsp_in;
      hdr_ff   <= hdr_in;
      wa_ff    <= wa_in;
      ra_ff    <= ra_in;
      cnt_ff   <= cnt_in;
      first_ff <= first_in;
   end

endmodule

@@ hw/rtl/rrb_checker.sv @@
// Port checker for the record ring buffer, bound to the top level.
`include "record_ring_buffer_assert.svh"

module rrb_checker (
   input logic             clock,
   input logic             reset,
   input logic             start,
   input logic             busy,
   input rrb_pkg::req_type req_item,
   input logic             rsp_strobe,
   input rrb_pkg::rsp_type rsp_item
);
   import rrb_pkg::*;

   `RRB_ASSERT_ALWAYS(a_reset_quiet, reset |=> !busy && !rsp_strobe, "not idle after reset")

   `RRB_ASSERT(a_write_one_cycle, start && !busy && req_item.mode == MODE_WRITE |=> rsp_strobe && !busy, "data write item did not finish in one cycle")

   `RRB_ASSERT(a_strobe_has_cause, rsp_strobe |-> $past(start && !busy) || $past(busy), "result without an item")

   `RRB_ASSERT(a_read_flags, rsp_strobe && (rsp_item.out_valid || rsp_item.first_of_record || rsp_item.last_of_record) |-> rsp_item.out_valid && rsp_item.status == ST_OK, "record flags without a valid byte")

endmodule

bind record_ring_buffer rrb_checker u_rrb_checker (.*);
